/* rtl/dlf_pkg.sv */
package dlf_pkg;

  // fixed field widths
  localparam int DATA_W  = 16;
  localparam int FRAC_W  = 12;
  localparam int ACT_W   = 32;
  localparam int ACC_W   = 48;
  localparam int NEUR_W  = 6;
  localparam int IPOS_W  = 10;
  localparam int ICNT_W  = 11;
  localparam int OCNT_W  = 7;
  localparam int CFG_AW  = 1;
  localparam int CFG_DW  = 11;

  // request codes on the input channel
  localparam logic [1:0] REQ_WEIGHT  = 2'd0;
  localparam logic [1:0] REQ_BIAS    = 2'd1;
  localparam logic [1:0] REQ_FEATURE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_INPUT_COUNT  = 1'd0;
  localparam logic [CFG_AW-1:0] REG_OUTPUT_COUNT = 1'd1;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [NEUR_W-1:0]        out_pos;
    logic [IPOS_W-1:0]        in_pos;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic [NEUR_W-1:0]       neuron;
    logic signed [ACT_W-1:0] activation;
    logic                    final_res;
  } out_item_t;

  // classified command passed from front to back
  typedef enum logic [1:0] {
    OP_WEIGHT,
    OP_BIAS,
    OP_FEAT
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic                     store;
    logic                     last;
    logic [NEUR_W-1:0]        out_pos;
    logic [IPOS_W-1:0]        in_pos;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_BIAS,
    B_MAC,
    B_DRAIN,
    B_EMIT
  } back_state_t;

endpackage

/* rtl/dense_layer_forward_unit.sv */
// load and plain feature transactions pass through the two-entry input queue and are then written
// a last feature runs one shared multiply-accumulate: per output neuron a bias load, input_count
// multiply-accumulate steps, a pipeline drain and an emit
// a result waits in the output register while the next neuron is computed
// reset (synchronous, active low) clears control state and sets input_count 1024, output_count 64;
// weight, bias and feature memories are not cleared and must be written before they are used
module dense_layer_forward_unit #(
  parameter int MAX_INPUTS  = 1024,
  parameter int MAX_OUTPUTS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dlf_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dlf_pkg::out_item_t          out_data,
  input  logic                        cfg_we,
  input  logic [dlf_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [dlf_pkg::CFG_DW-1:0]  cfg_wdata
);

  logic [dlf_pkg::ICNT_W-1:0] input_count_r;
  logic [dlf_pkg::OCNT_W-1:0] output_count_r;

  logic          cmd_valid;
  dlf_pkg::cmd_t cmd;
  logic          cmd_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_count_r  <= dlf_pkg::ICNT_W'(1024);
      output_count_r <= dlf_pkg::OCNT_W'(64);
    end else if (cfg_we) begin
      case (cfg_addr)
        dlf_pkg::REG_INPUT_COUNT: begin
          input_count_r <= cfg_wdata[dlf_pkg::ICNT_W-1:0];
        end
        dlf_pkg::REG_OUTPUT_COUNT: begin
          output_count_r <= cfg_wdata[dlf_pkg::OCNT_W-1:0];
        end
        default: begin
          input_count_r <= input_count_r;
        end
      endcase
    end
  end

  dlf_front #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  dlf_back #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .input_count  (input_count_r),
    .output_count (output_count_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

/* rtl/dlf_ram.sv */
module dlf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/dlf_front.sv */
module dlf_front #(
  parameter int MAX_INPUTS  = 1024,
  parameter int MAX_OUTPUTS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dlf_pkg::in_item_t in_data,
  output logic              cmd_valid,
  output dlf_pkg::cmd_t     cmd,
  input  logic              cmd_pop
);

  dlf_pkg::cmd_t q_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;
  logic [1:0]    cnt_nxt;

  dlf_pkg::cmd_t cls;
  logic          keep;
  logic          opos_ok;
  logic          ipos_ok;
  logic          push;

  assign opos_ok = (32'(in_data.out_pos) < MAX_OUTPUTS);
  assign ipos_ok = (32'(in_data.in_pos) < MAX_INPUTS);

  // classify the incoming transaction, drop what has no effect
  always_comb begin
    cls.store   = 1'b0;
    cls.last    = 1'b0;
    cls.out_pos = in_data.out_pos;
    cls.in_pos  = in_data.in_pos;
    cls.value   = in_data.value;
    cls.op      = dlf_pkg::OP_WEIGHT;
    keep        = 1'b0;
    case (in_data.req_type)
      dlf_pkg::REQ_WEIGHT: begin
        cls.op = dlf_pkg::OP_WEIGHT;
        keep   = opos_ok && ipos_ok;
      end
      dlf_pkg::REQ_BIAS: begin
        cls.op = dlf_pkg::OP_BIAS;
        keep   = opos_ok;
      end
      dlf_pkg::REQ_FEATURE: begin
        cls.op    = dlf_pkg::OP_FEAT;
        cls.store = ipos_ok;
        cls.last  = in_data.last;
        keep      = ipos_ok || in_data.last;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // two-entry queue toward the back end
  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready && keep;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign cnt_nxt   = cnt_r + {1'b0, push} - {1'b0, cmd_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (cmd_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

/* rtl/dlf_back.sv */
module dlf_back #(
  parameter int MAX_INPUTS  = 1024,
  parameter int MAX_OUTPUTS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  input  dlf_pkg::cmd_t               cmd,
  output logic                        cmd_pop,
  input  logic [dlf_pkg::ICNT_W-1:0]  input_count,
  input  logic [dlf_pkg::OCNT_W-1:0]  output_count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dlf_pkg::out_item_t          out_data
);

  localparam int KC_W    = $clog2(MAX_INPUTS + 1);
  localparam int FA_W    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int BA_W    = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int W_DEPTH = MAX_INPUTS * MAX_OUTPUTS;
  localparam int WA_W    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int DW      = dlf_pkg::DATA_W;
  localparam int AW      = dlf_pkg::ACC_W;
  localparam int SAT_LO  = dlf_pkg::FRAC_W + dlf_pkg::ACT_W - 1;

  dlf_pkg::back_state_t state_r;
  dlf_pkg::back_state_t state_nxt;

  logic [KC_W-1:0]             k_r;
  logic [KC_W-1:0]             ni_r;
  logic [dlf_pkg::NEUR_W-1:0]  j_r;
  logic [dlf_pkg::OCNT_W-1:0]  no_r;
  logic [WA_W-1:0]             wbase_r;
  logic                        rd_vld_r;
  logic                        prod_vld_r;
  logic                        bias_ld_r;
  logic signed [2*DW-1:0]      prod_r;
  logic signed [AW-1:0]        acc_r;
  logic                        out_valid_r;
  dlf_pkg::out_item_t          out_data_r;

  logic [KC_W-1:0]             ni_clamp;
  logic [dlf_pkg::OCNT_W-1:0]  no_clamp;
  logic                        start;
  logic                        mac_done;
  logic                        last_neuron;
  logic                        out_free;
  logic                        emit_go;
  logic signed [dlf_pkg::ACT_W-1:0] act_sat;

  logic            w_we;
  logic [WA_W-1:0] w_waddr;
  logic [WA_W-1:0] w_raddr;
  logic [DW-1:0]   w_q;
  logic            b_we;
  logic [BA_W-1:0] b_waddr;
  logic [BA_W-1:0] b_raddr;
  logic [DW-1:0]   b_q;
  logic            f_we;
  logic [FA_W-1:0] f_waddr;
  logic [FA_W-1:0] f_raddr;
  logic [DW-1:0]   f_q;

  // clamp the counts to the store sizes, and a zero count to one
  always_comb begin
    if (input_count == '0) begin
      ni_clamp = KC_W'(1);
    end else if (32'(input_count) > MAX_INPUTS) begin
      ni_clamp = KC_W'(MAX_INPUTS);
    end else begin
      ni_clamp = KC_W'(input_count);
    end
    if (output_count == '0) begin
      no_clamp = dlf_pkg::OCNT_W'(1);
    end else if (32'(output_count) > MAX_OUTPUTS) begin
      no_clamp = dlf_pkg::OCNT_W'(MAX_OUTPUTS);
    end else begin
      no_clamp = output_count;
    end
  end

  assign start       = (state_r == dlf_pkg::B_IDLE) && cmd_valid &&
                       (cmd.op == dlf_pkg::OP_FEAT) && cmd.last;
  assign mac_done    = ((k_r + KC_W'(1)) == ni_r);
  assign last_neuron = ((dlf_pkg::OCNT_W'(j_r) + dlf_pkg::OCNT_W'(1)) == no_r);
  assign out_free    = !out_valid_r || out_ready;
  assign emit_go     = (state_r == dlf_pkg::B_EMIT) && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dlf_pkg::B_IDLE: begin
        if (start) begin
          state_nxt = dlf_pkg::B_BIAS;
        end
      end
      dlf_pkg::B_BIAS: begin
        state_nxt = dlf_pkg::B_MAC;
      end
      dlf_pkg::B_MAC: begin
        if (mac_done) begin
          state_nxt = dlf_pkg::B_DRAIN;
        end
      end
      dlf_pkg::B_DRAIN: begin
        if (!rd_vld_r && !prod_vld_r) begin
          state_nxt = dlf_pkg::B_EMIT;
        end
      end
      dlf_pkg::B_EMIT: begin
        if (out_free) begin
          state_nxt = last_neuron ? dlf_pkg::B_IDLE : dlf_pkg::B_BIAS;
        end
      end
      default: begin
        state_nxt = dlf_pkg::B_IDLE;
      end
    endcase
  end

  // memory controls and queue pop
  always_comb begin
    cmd_pop = (state_r == dlf_pkg::B_IDLE) && cmd_valid;
    w_we    = cmd_pop && (cmd.op == dlf_pkg::OP_WEIGHT);
    b_we    = cmd_pop && (cmd.op == dlf_pkg::OP_BIAS);
    f_we    = cmd_pop && (cmd.op == dlf_pkg::OP_FEAT) && cmd.store;
    w_waddr = WA_W'(32'(cmd.out_pos) * MAX_INPUTS + 32'(cmd.in_pos));
    b_waddr = BA_W'(cmd.out_pos);
    f_waddr = FA_W'(cmd.in_pos);
    w_raddr = wbase_r + WA_W'(k_r);
    f_raddr = k_r[FA_W-1:0];
    b_raddr = j_r[BA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dlf_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencing counters and pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      ni_r        <= '0;
      j_r         <= '0;
      no_r        <= '0;
      wbase_r     <= '0;
      rd_vld_r    <= 1'b0;
      prod_vld_r  <= 1'b0;
      bias_ld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r   <= (state_r == dlf_pkg::B_MAC);
      prod_vld_r <= rd_vld_r;
      bias_ld_r  <= (state_r == dlf_pkg::B_BIAS);
      if (start) begin
        ni_r    <= ni_clamp;
        no_r    <= no_clamp;
        j_r     <= '0;
        wbase_r <= '0;
      end
      if (state_r == dlf_pkg::B_BIAS) begin
        k_r <= '0;
      end else if (state_r == dlf_pkg::B_MAC) begin
        k_r <= k_r + KC_W'(1);
      end
      if (emit_go && !last_neuron) begin
        j_r     <= j_r + dlf_pkg::NEUR_W'(1);
        wbase_r <= wbase_r + WA_W'(MAX_INPUTS);
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // multiply then accumulate; bias enters with the rounding half already added
  always_ff @(posedge clk) begin
    prod_r <= $signed(f_q) * $signed(w_q);
    if (bias_ld_r) begin
      acc_r <= {{(AW - DW - dlf_pkg::FRAC_W){b_q[DW-1]}}, b_q,
                1'b1, {(dlf_pkg::FRAC_W - 1){1'b0}}};
    end else if (prod_vld_r) begin
      acc_r <= acc_r + AW'(prod_r);
    end
  end

  // drop fraction bits and saturate to the result width
  always_comb begin
    if (!acc_r[AW-1] && (|acc_r[AW-2:SAT_LO])) begin
      act_sat = {1'b0, {(dlf_pkg::ACT_W - 1){1'b1}}};
    end else if (acc_r[AW-1] && !(&acc_r[AW-2:SAT_LO])) begin
      act_sat = {1'b1, {(dlf_pkg::ACT_W - 1){1'b0}}};
    end else begin
      act_sat = acc_r[SAT_LO:dlf_pkg::FRAC_W];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_data_r.neuron     <= j_r;
      out_data_r.activation <= act_sat;
      out_data_r.final_res  <= last_neuron;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  dlf_ram #(.WIDTH(DW), .DEPTH(W_DEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (cmd.value),
    .raddr (w_raddr),
    .rdata (w_q)
  );

  dlf_ram #(.WIDTH(DW), .DEPTH(MAX_OUTPUTS)) u_bias_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (cmd.value),
    .raddr (b_raddr),
    .rdata (b_q)
  );

  dlf_ram #(.WIDTH(DW), .DEPTH(MAX_INPUTS)) u_feature_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (cmd.value),
    .raddr (f_raddr),
    .rdata (f_q)
  );

endmodule

/* test/dense_layer_forward_unit_tb.sv */
`timescale 1ns / 1ps

module dense_layer_forward_unit_tb;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int SETTLE = 8;
  localparam int TAIL = 64;
  localparam int LIMIT = 5000;
  localparam longint ACT_MAX = 64'sd2147483647;
  localparam longint ACT_MIN = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  dlf_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  dlf_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [dlf_pkg::CFG_AW-1:0] cfg_addr = '0;
  logic [dlf_pkg::CFG_DW-1:0] cfg_wdata = '0;

  dense_layer_forward_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // predictor state: layer memories and count registers
  logic signed [dlf_pkg::DATA_W-1:0] weight_mem [64][1024];
  logic signed [dlf_pkg::DATA_W-1:0] bias_mem [64];
  logic signed [dlf_pkg::DATA_W-1:0] feat_mem [1024];
  logic [dlf_pkg::ICNT_W-1:0] icnt_reg = 11'd1024;
  logic [dlf_pkg::OCNT_W-1:0] ocnt_reg = 7'd64;
  dlf_pkg::out_item_t expected_acts [$];

  // stimulus side bookkeeping: entries that will be written before use
  bit weight_seen [64][1024];
  bit bias_seen [64];
  bit feat_seen [1024];
  dlf_pkg::in_item_t feed_q [$];
  int queued_total = 0;
  int accepted_total = 0;
  int predicted_results = 0;
  int err_count = 0;

  // pacing
  int gap_pct = 0;
  int stall_pct = 0;
  int in_gap = 0;
  int out_hold = 0;
  logic in_taken = 1'b0;
  int quiet_cycles = 0;
  dlf_pkg::out_item_t want;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int clamp_inputs(logic [dlf_pkg::ICNT_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > 1024) return 1024;
    return int'(raw);
  endfunction

  function automatic int clamp_outputs(logic [dlf_pkg::OCNT_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > 64) return 64;
    return int'(raw);
  endfunction

  // bias plus dot product per neuron, rounded half up and saturated
  function automatic void eval_layer();
    int ni;
    int no;
    longint acc;
    longint q;
    dlf_pkg::out_item_t r;
    ni = clamp_inputs(icnt_reg);
    no = clamp_outputs(ocnt_reg);
    for (int j = 0; j < no; j++) begin
      acc = longint'(bias_mem[j]) <<< dlf_pkg::FRAC_W;
      for (int k = 0; k < ni; k++) begin
        acc += longint'(feat_mem[k]) * longint'(weight_mem[j][k]);
      end
      acc += longint'(1) <<< (dlf_pkg::FRAC_W - 1);
      q = acc >>> dlf_pkg::FRAC_W;
      r.neuron = j[dlf_pkg::NEUR_W-1:0];
      if (q > ACT_MAX) r.activation = 32'h7FFF_FFFF;
      else if (q < ACT_MIN) r.activation = 32'h8000_0000;
      else r.activation = q[31:0];
      r.final_res = (j == no - 1);
      expected_acts.push_back(r);
    end
  endfunction

  // apply one accepted input transaction to the predictor
  function automatic void absorb_item(dlf_pkg::in_item_t it);
    case (it.req_type)
      dlf_pkg::REQ_WEIGHT: weight_mem[it.out_pos][it.in_pos] = it.value;
      dlf_pkg::REQ_BIAS: bias_mem[it.out_pos] = it.value;
      dlf_pkg::REQ_FEATURE: begin
        feat_mem[it.in_pos] = it.value;
        if (it.last) eval_layer();
      end
      default: ;
    endcase
  endfunction

  function automatic int rand_value();
    case ($urandom_range(7))
      0: return 32'hFFFF_8000;
      1: return 32767;
      2: return 0;
      default: return int'($urandom_range(65535));
    endcase
  endfunction

  function automatic dlf_pkg::in_item_t make_item(logic [1:0] req, int opos, int ipos,
                                                  int val, bit last);
    dlf_pkg::in_item_t it;
    it.req_type = req;
    it.out_pos = opos[dlf_pkg::NEUR_W-1:0];
    it.in_pos = ipos[dlf_pkg::IPOS_W-1:0];
    it.value = val[dlf_pkg::DATA_W-1:0];
    it.last = last;
    case (req)
      dlf_pkg::REQ_WEIGHT: weight_seen[it.out_pos][it.in_pos] = 1'b1;
      dlf_pkg::REQ_BIAS: bias_seen[it.out_pos] = 1'b1;
      dlf_pkg::REQ_FEATURE: feat_seen[it.in_pos] = 1'b1;
      default: ;
    endcase
    return it;
  endfunction

  function automatic void queue_item(dlf_pkg::in_item_t it);
    feed_q.push_back(it);
    queued_total++;
  endfunction

  // input driver
  always @(negedge clk) begin
    if (in_valid && !in_taken) begin
      // hold until the transaction is taken
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_valid <= 1'b0;
    end else if (feed_q.size() > 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      in_gap <= $urandom_range(5);
    end else if (feed_q.size() > 0) begin
      in_data <= feed_q.pop_front();
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(99) < stall_pct) begin
      out_ready <= 1'b0;
      out_hold <= $urandom_range(5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // input monitor feeds the predictor
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      absorb_item(in_data);
      accepted_total <= accepted_total + 1;
    end
  end

  // result monitor and compare
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_acts.size() == 0) begin
        $error("unexpected result transaction: neuron %0d activation %0d",
               out_data.neuron, $signed(out_data.activation));
        err_count++;
      end else begin
        want = expected_acts.pop_front();
        if (out_data.neuron !== want.neuron) begin
          $error("neuron mismatch: expected %0d, actual %0d", want.neuron, out_data.neuron);
          err_count++;
        end
        if (out_data.activation !== want.activation) begin
          $error("activation mismatch: expected %0d, actual %0d",
                 $signed(want.activation), $signed(out_data.activation));
          err_count++;
        end
        if (out_data.final_res !== want.final_res) begin
          $error("final_res mismatch: expected %0d, actual %0d",
                 want.final_res, out_data.final_res);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic drain();
    while (accepted_total != queued_total || expected_acts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [dlf_pkg::CFG_AW-1:0] idx, int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[dlf_pkg::CFG_DW-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == dlf_pkg::REG_INPUT_COUNT) icnt_reg = val[dlf_pkg::ICNT_W-1:0];
    else ocnt_reg = val[dlf_pkg::OCNT_W-1:0];
  endtask

  task automatic apply_counts(int icnt, int ocnt);
    drain();
    write_reg(dlf_pkg::REG_INPUT_COUNT, icnt);
    write_reg(dlf_pkg::REG_OUTPUT_COUNT, ocnt);
  endtask

  task automatic set_pace();
    case ($urandom_range(3))
      0: gap_pct = 0;
      1: gap_pct = 10;
      default: gap_pct = 35;
    endcase
    case ($urandom_range(3))
      0: stall_pct = 0;
      1: stall_pct = 10;
      default: stall_pct = 35;
    endcase
  endtask

  // one well formed vector: missing loads and features, a few extras,
  // shuffled, then the feature marked last
  task automatic build_vector(output int n_items);
    dlf_pkg::in_item_t batch [$];
    dlf_pkg::in_item_t tmp;
    int ni;
    int no;
    int m;
    int ipos;
    ni = clamp_inputs(icnt_reg);
    no = clamp_outputs(ocnt_reg);
    for (int j = 0; j < no; j++) begin
      for (int k = 0; k < ni; k++) begin
        if (!weight_seen[j][k])
          batch.push_back(make_item(dlf_pkg::REQ_WEIGHT, j, k, rand_value(),
                                    1'($urandom_range(1))));
      end
      if (!bias_seen[j])
        batch.push_back(make_item(dlf_pkg::REQ_BIAS, j, $urandom_range(1023), rand_value(),
                                  1'($urandom_range(1))));
    end
    for (int k = 0; k < ni; k++) begin
      if (!feat_seen[k])
        batch.push_back(make_item(dlf_pkg::REQ_FEATURE, $urandom_range(63), k, rand_value(),
                                  1'b0));
    end
    repeat ($urandom_range(4)) begin
      case ($urandom_range(5))
        0: batch.push_back(make_item(dlf_pkg::REQ_WEIGHT, $urandom_range(no - 1),
                                     $urandom_range(ni - 1), rand_value(),
                                     1'($urandom_range(1))));
        1: batch.push_back(make_item(dlf_pkg::REQ_BIAS, $urandom_range(no - 1),
                                     $urandom_range(1023), rand_value(),
                                     1'($urandom_range(1))));
        2: batch.push_back(make_item(dlf_pkg::REQ_FEATURE, $urandom_range(63),
                                     $urandom_range(ni - 1), rand_value(), 1'b0));
        3: batch.push_back(make_item(REQ_UNUSED, $urandom_range(63), $urandom_range(1023),
                                     rand_value(), 1'($urandom_range(1))));
        4: batch.push_back(make_item(dlf_pkg::REQ_WEIGHT, $urandom_range(63),
                                     $urandom_range(1023), rand_value(),
                                     1'($urandom_range(1))));
        default: batch.push_back(make_item(dlf_pkg::REQ_FEATURE, $urandom_range(63),
                                           $urandom_range(1023), rand_value(), 1'b0));
      endcase
    end
    for (int i = batch.size() - 1; i > 0; i--) begin
      m = $urandom_range(i);
      tmp = batch[i];
      batch[i] = batch[m];
      batch[m] = tmp;
    end
    ipos = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(ni - 1);
    batch.push_back(make_item(dlf_pkg::REQ_FEATURE, $urandom_range(63), ipos, rand_value(),
                              1'b1));
    foreach (batch[i]) queue_item(batch[i]);
    n_items = batch.size();
    predicted_results += no;
  endtask

  // widest output count, clamped counts and junk in the upper data bits
  task automatic wide_phases();
    int n;
    apply_counts(1, 127);
    build_vector(n);
    apply_counts(3, 11'h400);
    build_vector(n);
  endtask

  initial begin
    int n;
    int icnt;
    int ocnt;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extreme values, every request type, last on loads
    write_reg(dlf_pkg::REG_INPUT_COUNT, 2);
    write_reg(dlf_pkg::REG_OUTPUT_COUNT, 2);
    queue_item(make_item(dlf_pkg::REQ_WEIGHT, 0, 0, 32767, 1'b0));
    queue_item(make_item(dlf_pkg::REQ_WEIGHT, 0, 1, -32768, 1'b1));
    queue_item(make_item(dlf_pkg::REQ_WEIGHT, 1, 0, -32768, 1'b0));
    queue_item(make_item(dlf_pkg::REQ_WEIGHT, 1, 1, -32768, 1'b0));
    queue_item(make_item(dlf_pkg::REQ_BIAS, 0, 0, 32767, 1'b0));
    queue_item(make_item(dlf_pkg::REQ_BIAS, 1, 1023, -32768, 1'b1));
    queue_item(make_item(dlf_pkg::REQ_WEIGHT, 63, 1023, -32768, 1'b0));
    queue_item(make_item(dlf_pkg::REQ_BIAS, 63, 0, 32767, 1'b0));
    queue_item(make_item(REQ_UNUSED, 63, 1023, -1, 1'b1));
    queue_item(make_item(REQ_UNUSED, 0, 0, 0, 1'b0));
    queue_item(make_item(dlf_pkg::REQ_FEATURE, 0, 0, -32768, 1'b0));
    queue_item(make_item(dlf_pkg::REQ_FEATURE, 63, 1, -32768, 1'b0));
    queue_item(make_item(dlf_pkg::REQ_FEATURE, 0, 1023, 32767, 1'b0));
    queue_item(make_item(dlf_pkg::REQ_FEATURE, 63, 1023, -32768, 1'b1));

    // directed: zero counts clamp to one, rounding of exact halves
    apply_counts(0, 0);
    queue_item(make_item(dlf_pkg::REQ_WEIGHT, 0, 0, 1, 1'b0));
    queue_item(make_item(dlf_pkg::REQ_BIAS, 0, 0, 0, 1'b0));
    queue_item(make_item(dlf_pkg::REQ_FEATURE, 0, 0, 2048, 1'b1));
    queue_item(make_item(dlf_pkg::REQ_FEATURE, 0, 0, -2048, 1'b1));
    queue_item(make_item(dlf_pkg::REQ_WEIGHT, 0, 0, 3, 1'b0));
    queue_item(make_item(dlf_pkg::REQ_FEATURE, 0, 0, -2048, 1'b1));
    queue_item(make_item(dlf_pkg::REQ_FEATURE, 0, 0, 6144, 1'b1));

    set_pace();
    wide_phases();

    // random vectors, counts changed only between drained phases
    while (queued_total < 170 || predicted_results < 60) begin
      set_pace();
      if ($urandom_range(99) < 40) begin
        icnt = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
        ocnt = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
        apply_counts(icnt, ocnt | ($urandom_range(15) << 7));
      end else if ($urandom_range(99) < 15) begin
        drain();
      end
      build_vector(n);
    end

    // closing stretch without idling
    gap_pct = 0;
    stall_pct = 0;
    repeat (3) build_vector(n);

    drain();
    repeat (TAIL) @(posedge clk);
    if (err_count == 0 && expected_acts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/dlf_pkg.sv
rtl/dlf_ram.sv
rtl/dlf_front.sv
rtl/dlf_back.sv
rtl/dense_layer_forward_unit.sv
test/dense_layer_forward_unit_tb.sv
